FILE: src/utv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utv_pkg
// Types, constants and helpers shared by the UTF-8 text validator.
// ----------------------------------------------------------------------------
package utv_pkg;

   localparam int BYTE_W      = 8;
   localparam int MAX_LEN_W   = 13;
   localparam int COUNT_OUT_W = 13;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 13;

   localparam logic [MAX_LEN_W-1:0] MAX_LENGTH_RESET = 13'd4096;

   localparam logic [BYTE_W-1:0] ASCII_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] ASCII_DEL   = 8'h7f;
   localparam logic [BYTE_W-1:0] LEAD2_LO    = 8'hc2;
   localparam logic [BYTE_W-1:0] LEAD2_HI    = 8'hdf;
   localparam logic [BYTE_W-1:0] LEAD3_LO    = 8'he0;
   localparam logic [BYTE_W-1:0] LEAD3_HI    = 8'hef;
   localparam logic [BYTE_W-1:0] LEAD3_SURR  = 8'hed;
   localparam logic [BYTE_W-1:0] LEAD4_LO    = 8'hf0;
   localparam logic [BYTE_W-1:0] LEAD4_HI    = 8'hf4;
   localparam logic [BYTE_W-1:0] CONT_LO     = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_HI     = 8'hbf;
   localparam logic [BYTE_W-1:0] CONT_A0     = 8'ha0;
   localparam logic [BYTE_W-1:0] CONT_9F     = 8'h9f;
   localparam logic [BYTE_W-1:0] CONT_90     = 8'h90;
   localparam logic [BYTE_W-1:0] CONT_8F     = 8'h8f;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_LENGTH = 1'b0,
      CSR_IDENT_ONLY = 1'b1
   } csr_index_type;

   // range rule for the second byte of a sequence
   typedef enum logic [2:0] {
      LEAD_ANY = 3'd0,
      LEAD_C2  = 3'd1,
      LEAD_E0  = 3'd2,
      LEAD_ED  = 3'd3,
      LEAD_F0  = 3'd4,
      LEAD_F4  = 3'd5
   } lead_class_type;

   typedef struct packed {
      logic              valid;
      logic [BYTE_W-1:0] text_byte;
      logic              final_byte;
   } stage_type;

   function automatic logic is_ident_char(input logic [BYTE_W-1:0] b);
      is_ident_char = (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h41 && b <= 8'h5a) ||
                      (b >= 8'h30 && b <= 8'h39) || b == 8'h5f || b == 8'h2d ||
                      b == 8'h2e;
   endfunction

endpackage

FILE: src/utv_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utv_req_if
// Byte channel into the validator: one text byte and its last-byte mark.
// ----------------------------------------------------------------------------
interface utv_req_if;
   logic                      valid;
   logic                      ready;
   logic [utv_pkg::BYTE_W-1:0] text_byte;
   logic                      final_byte;

   modport source (output valid, output text_byte, output final_byte, input ready);
   modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

FILE: src/utv_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utv_rsp_if
// Verdict channel out of the validator: pass flag and byte count.
// ----------------------------------------------------------------------------
interface utv_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            text_ok;
   logic [utv_pkg::COUNT_OUT_W-1:0] byte_count;

   modport source (output valid, output text_ok, output byte_count, input ready);
   modport sink   (input valid, input text_ok, input byte_count, output ready);
endinterface

FILE: src/utv_csr_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utv_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface utv_csr_if;
   logic                           valid;
   logic                           ready;
   logic [utv_pkg::CSR_IDX_W-1:0]  index;
   logic [utv_pkg::CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: src/utv_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utv_in_reg
// Input register: captures one byte item per cycle while the checker advances.
// ----------------------------------------------------------------------------
module utv_in_reg (
   input  logic               clock,
   input  logic               reset,
   utv_req_if.sink            req,
   input  logic               advance,
   output utv_pkg::stage_type stage
);

   utv_pkg::stage_type stage_ff;
   utv_pkg::stage_type stage_in;

   assign req.ready = advance;
   assign stage     = stage_ff;

   always_comb begin
      stage_in = stage_ff;
      if (advance) begin
         stage_in.valid = req.valid;
         if (req.valid) begin
            stage_in.text_byte  = req.text_byte;
            stage_in.final_byte = req.final_byte;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff.valid <= 1'b0;
      end else begin
         stage_ff.valid <= stage_in.valid;
      end
      stage_ff.text_byte  <= stage_in.text_byte;
      stage_ff.final_byte <= stage_in.final_byte;
   end

endmodule

FILE: src/utv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utv_checker
// Per-byte UTF-8 rules, per-text state and the verdict register.
// ----------------------------------------------------------------------------
module utv_checker #(
   parameter int LENGTH_LIMIT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   input  utv_pkg::stage_type                  stage,
   input  logic [utv_pkg::MAX_LEN_W-1:0]       max_length,
   input  logic                                identifier_only,
   output logic                                advance,
   utv_rsp_if.source                           rsp
);

   localparam int CNT_W = $clog2(LENGTH_LIMIT + 2);
   localparam int CMP_W = (CNT_W > utv_pkg::MAX_LEN_W) ? CNT_W : utv_pkg::MAX_LEN_W;
   localparam logic [CNT_W-1:0] CNT_SAT = CNT_W'(LENGTH_LIMIT + 1);

   logic [1:0]                 pending_ff, pending_in;
   utv_pkg::lead_class_type    lead_ff, lead_in;
   logic                       second_ff, second_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic                       failed_ff, failed_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_ok_ff, rsp_ok_in;
   logic [utv_pkg::COUNT_OUT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                        process;
   logic [utv_pkg::BYTE_W-1:0]  b;
   logic [utv_pkg::BYTE_W-1:0]  lo;
   logic [utv_pkg::BYTE_W-1:0]  hi;
   logic [CNT_W-1:0]            count_next;
   logic [1:0]                  pending_next;
   logic                        fail_next;
   logic                        over_length;

   assign advance = !stage.valid || !stage.final_byte || !rsp_valid_ff || rsp.ready;
   assign process = stage.valid && advance;
   assign b       = stage.text_byte;

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.text_ok    = rsp_ok_ff;
   assign rsp.byte_count = rsp_count_ff;

   always_comb begin
      lo = utv_pkg::CONT_LO;
      hi = utv_pkg::CONT_HI;
      if (second_ff) begin
         unique case (lead_ff)
            utv_pkg::LEAD_C2, utv_pkg::LEAD_E0: lo = utv_pkg::CONT_A0;
            utv_pkg::LEAD_ED:                   hi = utv_pkg::CONT_9F;
            utv_pkg::LEAD_F0:                   lo = utv_pkg::CONT_90;
            utv_pkg::LEAD_F4:                   hi = utv_pkg::CONT_8F;
            default:                            lo = utv_pkg::CONT_LO;
         endcase
      end
   end

   always_comb begin
      pending_in   = pending_ff;
      lead_in      = lead_ff;
      second_in    = second_ff;
      count_in     = count_ff;
      failed_in    = failed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_count_in = rsp_count_ff;

      count_next   = (count_ff < CNT_SAT) ? count_ff + CNT_W'(1) : count_ff;
      pending_next = pending_ff;
      fail_next    = failed_ff || (identifier_only && !utv_pkg::is_ident_char(b));
      over_length  = 1'b0;

      if (process) begin
         lead_in   = lead_ff;
         second_in = second_ff;
         priority if (pending_ff != 2'd0) begin
            if (b < lo || b > hi) begin
               fail_next = 1'b1;
            end
            pending_next = pending_ff - 2'd1;
            second_in    = 1'b0;
            lead_in      = utv_pkg::LEAD_ANY;
         end else if (b <= utv_pkg::ASCII_DEL) begin
            if (b < utv_pkg::ASCII_SPACE || b == utv_pkg::ASCII_DEL) begin
               fail_next = 1'b1;
            end
         end else if (b >= utv_pkg::LEAD2_LO && b <= utv_pkg::LEAD2_HI) begin
            pending_next = 2'd1;
            second_in    = 1'b1;
            lead_in      = (b == utv_pkg::LEAD2_LO) ? utv_pkg::LEAD_C2 : utv_pkg::LEAD_ANY;
         end else if (b >= utv_pkg::LEAD3_LO && b <= utv_pkg::LEAD3_HI) begin
            pending_next = 2'd2;
            second_in    = 1'b1;
            lead_in      = (b == utv_pkg::LEAD3_LO)   ? utv_pkg::LEAD_E0 :
                           (b == utv_pkg::LEAD3_SURR) ? utv_pkg::LEAD_ED : utv_pkg::LEAD_ANY;
         end else if (b >= utv_pkg::LEAD4_LO && b <= utv_pkg::LEAD4_HI) begin
            pending_next = 2'd3;
            second_in    = 1'b1;
            lead_in      = (b == utv_pkg::LEAD4_LO) ? utv_pkg::LEAD_F0 :
                           (b == utv_pkg::LEAD4_HI) ? utv_pkg::LEAD_F4 : utv_pkg::LEAD_ANY;
         end else begin
            fail_next = 1'b1;
         end

         // count saturates just above the limit; the saturated value is also over length
         over_length = (CMP_W'(count_next) > CMP_W'(max_length)) || (count_next == CNT_SAT);

         if (stage.final_byte) begin
            rsp_valid_in = 1'b1;
            rsp_ok_in    = !(fail_next || pending_next != 2'd0 || over_length);
            rsp_count_in = utv_pkg::COUNT_OUT_W'(count_next);
            pending_in   = 2'd0;
            lead_in      = utv_pkg::LEAD_ANY;
            second_in    = 1'b0;
            count_in     = '0;
            failed_in    = 1'b0;
         end else begin
            pending_in = pending_next;
            count_in   = count_next;
            failed_in  = fail_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff   <= 2'd0;
         lead_ff      <= utv_pkg::LEAD_ANY;
         second_ff    <= 1'b0;
         count_ff     <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pending_ff   <= pending_in;
         lead_ff      <= lead_in;
         second_ff    <= second_in;
         count_ff     <= count_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff    <= rsp_ok_in;
      rsp_count_ff <= rsp_count_in;
   end

   // second-byte flag only while a sequence is open
   a_second_needs_pending: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> pending_ff != 2'd0)
      else $error("second byte due with no sequence open");

   a_lead_needs_second: assert property (@(posedge clock) disable iff (reset)
      lead_ff != utv_pkg::LEAD_ANY |-> second_ff)
      else $error("lead class held past the second byte");

   // a final byte returns the text state to zero
   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      process && stage.final_byte |=> count_ff == '0 && !failed_ff && pending_ff == 2'd0)
      else $error("text state not cleared after final byte");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp.ready |-> !(process && stage.final_byte))
      else $error("verdict overwritten while waiting");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_SAT)
      else $error("byte count beyond saturation");

endmodule

FILE: src/utv_text_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_text_validator
// Strict UTF-8 checker for byte-serial texts with length and identifier rules.
// ----------------------------------------------------------------------------
// verdict path: the edge that accepts the final byte puts it in the input reg,
// and the verdict reg then registers the verdict for it
// throughput: 1 byte per cycle while not stalled, set by the checker state update
// verdict-side backpressure stalls only when a final byte meets a full, untaken verdict reg
// reset clears text state, verdict valid, max_length to 4096 and identifier mode off
module utf8_text_validator #(
   parameter int LENGTH_LIMIT = 4096
) (
   input  logic      clock,
   input  logic      reset,
   utv_req_if.sink   req,
   utv_rsp_if.source rsp,
   utv_csr_if.sink   csr
);

   logic [utv_pkg::MAX_LEN_W-1:0] max_length_ff, max_length_in;
   logic                          ident_only_ff, ident_only_in;
   utv_pkg::stage_type            stage;
   logic                          advance;

   assign csr.ready = 1'b1;

   always_comb begin
      max_length_in = max_length_ff;
      ident_only_in = ident_only_ff;
      if (csr.valid) begin
         unique case (utv_pkg::csr_index_type'(csr.index))
            utv_pkg::CSR_MAX_LENGTH: max_length_in = csr.data[utv_pkg::MAX_LEN_W-1:0];
            utv_pkg::CSR_IDENT_ONLY: ident_only_in = csr.data[0];
            default:                 max_length_in = max_length_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= utv_pkg::MAX_LENGTH_RESET;
         ident_only_ff <= 1'b0;
      end else begin
         max_length_ff <= max_length_in;
         ident_only_ff <= ident_only_in;
      end
   end

   utv_in_reg u_in_reg (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .advance (advance),
      .stage   (stage)
   );

   utv_checker #(
      .LENGTH_LIMIT (LENGTH_LIMIT)
   ) u_checker (
      .clock           (clock),
      .reset           (reset),
      .stage           (stage),
      .max_length      (max_length_ff),
      .identifier_only (ident_only_ff),
      .advance         (advance),
      .rsp             (rsp)
   );

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UTF-8 text validator. Texts go in one byte per
// item and a local checker predicts the verdict of each one. Register
// settings change between phases, covering length caps, identifier mode and
// texts at and just over a length cap.
// ----------------------------------------------------------------------------
module testbench;

   localparam int TEXT_LIMIT = 4096;
   localparam int PHASES     = 10;

   typedef struct packed {
      logic                            ok;
      logic [utv_pkg::COUNT_OUT_W-1:0] count;
   } verdict_type;

   typedef struct {
      logic [utv_pkg::BYTE_W-1:0] value;
      logic                       last;
      bit                         drain;
   } text_item_type;

   logic clock;
   logic reset;

   utv_req_if req_ch();
   utv_rsp_if rsp_ch();
   utv_csr_if csr_ch();

   utf8_text_validator #(.LENGTH_LIMIT(TEXT_LIMIT)) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   // checker copy of the block state and registers
   logic [utv_pkg::MAX_LEN_W-1:0] len_cap;
   logic                          ident_mode;
   logic [1:0]                    cont_left;
   utv_pkg::lead_class_type       second_rule;
   logic                          at_second;
   logic [utv_pkg::MAX_LEN_W-1:0] text_len;
   logic                          text_bad;

   text_item_type              send_q[$];
   verdict_type                verdict_q[$];
   logic [utv_pkg::BYTE_W-1:0] text_buf[$];

   bit req_fired;
   bit idle_on;
   int send_gap;
   int stall_left;
   int bytes_queued;
   int bytes_taken;
   int texts_made;
   int settings_made;
   int n_pass;
   int n_reject;
   int bad_count;

   initial begin
      clock = 1'b0;
   end

   always #4 clock = ~clock;

   function automatic void add_byte(input logic [utv_pkg::BYTE_W-1:0] b);
      text_buf.insert(text_buf.size(), b);
   endfunction

   function automatic logic name_char(input logic [utv_pkg::BYTE_W-1:0] b);
      logic [utv_pkg::BYTE_W-1:0] folded;
      folded = b | 8'h20;
      return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
             (b >= 8'h30 && b <= 8'h39) || b == 8'h5f || b == 8'h2d || b == 8'h2e ||
             (folded >= 8'h61 && folded <= 8'h7a && b < 8'h80);
   endfunction

   // one byte through the checker; a verdict only on the last byte
   function automatic void judge_byte(input logic [utv_pkg::BYTE_W-1:0] b, input logic fin,
                                      output logic has_v, output verdict_type v);
      logic [utv_pkg::BYTE_W-1:0] lo;
      logic [utv_pkg::BYTE_W-1:0] hi;
      int lim;
      has_v = 1'b0;
      v = '0;
      if (int'(text_len) < TEXT_LIMIT + 1) text_len = text_len + 1'b1;
      if (ident_mode && !name_char(b)) text_bad = 1'b1;
      if (cont_left != 2'd0) begin
         lo = utv_pkg::CONT_LO;
         hi = utv_pkg::CONT_HI;
         if (at_second) begin
            case (second_rule)
               utv_pkg::LEAD_C2, utv_pkg::LEAD_E0: lo = utv_pkg::CONT_A0;
               utv_pkg::LEAD_ED: hi = utv_pkg::CONT_9F;
               utv_pkg::LEAD_F0: lo = utv_pkg::CONT_90;
               utv_pkg::LEAD_F4: hi = utv_pkg::CONT_8F;
               default: ;
            endcase
         end
         if (b < lo || b > hi) text_bad = 1'b1;
         cont_left = cont_left - 1'b1;
         at_second = 1'b0;
         second_rule = utv_pkg::LEAD_ANY;
      end else if (b <= utv_pkg::ASCII_DEL) begin
         if (b < utv_pkg::ASCII_SPACE || b == utv_pkg::ASCII_DEL) text_bad = 1'b1;
      end else if (b >= utv_pkg::LEAD2_LO && b <= utv_pkg::LEAD2_HI) begin
         cont_left = 2'd1;
         at_second = 1'b1;
         second_rule = (b == utv_pkg::LEAD2_LO) ? utv_pkg::LEAD_C2 : utv_pkg::LEAD_ANY;
      end else if (b >= utv_pkg::LEAD3_LO && b <= utv_pkg::LEAD3_HI) begin
         cont_left = 2'd2;
         at_second = 1'b1;
         second_rule = (b == utv_pkg::LEAD3_LO)   ? utv_pkg::LEAD_E0 :
                       (b == utv_pkg::LEAD3_SURR) ? utv_pkg::LEAD_ED : utv_pkg::LEAD_ANY;
      end else if (b >= utv_pkg::LEAD4_LO && b <= utv_pkg::LEAD4_HI) begin
         cont_left = 2'd3;
         at_second = 1'b1;
         second_rule = (b == utv_pkg::LEAD4_LO) ? utv_pkg::LEAD_F0 :
                       (b == utv_pkg::LEAD4_HI) ? utv_pkg::LEAD_F4 : utv_pkg::LEAD_ANY;
      end else begin
         text_bad = 1'b1;
      end
      if (fin) begin
         if (cont_left != 2'd0) text_bad = 1'b1;
         lim = (int'(len_cap) > TEXT_LIMIT) ? TEXT_LIMIT : int'(len_cap);
         if (int'(text_len) > lim) text_bad = 1'b1;
         has_v = 1'b1;
         v.ok = !text_bad;
         v.count = text_len;
         cont_left = 2'd0;
         second_rule = utv_pkg::LEAD_ANY;
         at_second = 1'b0;
         text_len = '0;
         text_bad = 1'b0;
      end
   endfunction

   task automatic report_bad(input string what, input verdict_type want,
                             input verdict_type got);
      bad_count++;
      if (bad_count <= 10)
         $display("mismatch: %s: expected ok=%0b count=%0d, got ok=%0b count=%0d",
                  what, want.ok, want.count, got.ok, got.count);
   endtask

   // sample both channels at the rising edge
   always @(posedge clock) begin : watch_channels
      verdict_type got;
      verdict_type want;
      logic has_v;
      req_fired = !reset && req_ch.valid === 1'b1 && req_ch.ready === 1'b1;
      if (req_fired) begin
         bytes_taken++;
         judge_byte(req_ch.text_byte, req_ch.final_byte, has_v, want);
         if (has_v) verdict_q.insert(verdict_q.size(), want);
      end
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.ok = rsp_ch.text_ok;
         got.count = rsp_ch.byte_count;
         if (verdict_q.size() == 0) begin
            report_bad("verdict with no text pending", '0, got);
         end else begin
            want = verdict_q.pop_front();
            if (got.ok !== want.ok || got.count !== want.count)
               report_bad("verdict differs", want, got);
            if (want.ok) n_pass++;
            else n_reject++;
         end
      end
   end

   always @(negedge clock) begin : drive_bytes
      logic next_valid;
      text_item_type it;
      next_valid = req_ch.valid;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_fired) next_valid = 1'b0;
         if (!next_valid) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (idle_on && $urandom_range(7, 0) == 0) begin
               send_gap = $urandom_range(3, 0);
            end else if (send_q.size() > 0 && !(send_q[0].drain && verdict_q.size() != 0)) begin
               it = send_q.pop_front();
               next_valid = 1'b1;
               req_ch.text_byte <= it.value;
               req_ch.final_byte <= it.last;
            end
         end
      end
      req_ch.valid <= next_valid;
   end

   always @(negedge clock) begin : drive_ready
      if (stall_left > 0) begin
         stall_left--;
         rsp_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(5, 0) == 0) begin
         stall_left = $urandom_range(3, 0);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   function automatic void put_range(input int lo, input int hi);
      add_byte(8'($urandom_range(hi, lo)));
   endfunction

   // one well-formed character of random width
   function automatic void put_char();
      case ($urandom_range(11, 0))
         0, 1, 2, 3: put_range(8'h20, 8'h7e);
         4: begin
            add_byte(utv_pkg::LEAD2_LO);
            put_range(utv_pkg::CONT_A0, utv_pkg::CONT_HI);
         end
         5: begin
            put_range(8'hc3, utv_pkg::LEAD2_HI);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
         end
         6: begin
            add_byte(utv_pkg::LEAD3_LO);
            put_range(utv_pkg::CONT_A0, utv_pkg::CONT_HI);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
         end
         7: begin
            put_range(8'he1, 8'hec);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
         end
         8: begin
            add_byte(utv_pkg::LEAD3_SURR);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_9F);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
         end
         9: begin
            put_range(8'hee, utv_pkg::LEAD3_HI);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
         end
         10: begin
            if ($urandom_range(1, 0) == 0) begin
               add_byte(utv_pkg::LEAD4_LO);
               put_range(utv_pkg::CONT_90, utv_pkg::CONT_HI);
            end else begin
               put_range(8'hf1, 8'hf3);
               put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
            end
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
         end
         default: begin
            add_byte(utv_pkg::LEAD4_HI);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_8F);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
            put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
         end
      endcase
   endfunction

   function automatic void put_name_char();
      int unsigned r;
      r = $urandom_range(64, 0);
      if (r < 26) add_byte(8'h61 + 8'(r));
      else if (r < 52) add_byte(8'h41 + 8'(r - 26));
      else if (r < 62) add_byte(8'h30 + 8'(r - 52));
      else if (r == 62) add_byte(8'h5f);
      else if (r == 63) add_byte(8'h2d);
      else add_byte(8'h2e);
   endfunction

   // hand the buffered text to the driver, marking its last byte
   function automatic void commit_text(input bit drain);
      text_item_type it;
      foreach (text_buf[i]) begin
         it.value = text_buf[i];
         it.last = (i == text_buf.size() - 1);
         it.drain = drain && (i == 0);
         send_q.insert(send_q.size(), it);
      end
      bytes_queued += text_buf.size();
      texts_made++;
      text_buf.delete();
   endfunction

   function automatic void make_random_text(input bit name_phase);
      int n;
      int style;
      int lead;
      int need;
      n = ($urandom_range(9, 0) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
      style = $urandom_range(99, 0);
      if (style >= 92) begin
         repeat (n) put_range(0, 255);
      end else begin
         repeat (n) begin
            if (name_phase && $urandom_range(9, 0) != 0) put_name_char();
            else put_char();
         end
         if (style >= 60 && style < 75) begin
            text_buf[$urandom_range(text_buf.size() - 1, 0)] = 8'($urandom_range(255, 0));
         end else if (style >= 75 && style < 84) begin
            // sequence cut short by the end of text
            lead = $urandom_range(utv_pkg::LEAD4_HI, utv_pkg::LEAD2_LO);
            need = (lead <= utv_pkg::LEAD2_HI) ? 1 : (lead <= utv_pkg::LEAD3_HI) ? 2 : 3;
            add_byte(8'(lead));
            repeat ($urandom_range(need - 1, 0)) put_range(utv_pkg::CONT_LO, utv_pkg::CONT_HI);
         end else if (style >= 84) begin
            text_buf.insert($urandom_range(text_buf.size(), 0),
                            8'($urandom_range(utv_pkg::CONT_HI, utv_pkg::CONT_LO)));
         end
      end
      commit_text($urandom_range(24, 0) == 0);
   endfunction

   task automatic write_reg(input utv_pkg::csr_index_type idx,
                            input logic [utv_pkg::CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= val;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      case (idx)
         utv_pkg::CSR_MAX_LENGTH: len_cap = val;
         utv_pkg::CSR_IDENT_ONLY: ident_mode = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // registers change only once the block has drained
   task automatic set_mode(input logic [utv_pkg::MAX_LEN_W-1:0] cap, input logic ident,
                           input bit idle);
      do @(negedge clock); while (bytes_taken != bytes_queued || verdict_q.size() != 0);
      repeat (4) @(negedge clock);
      write_reg(utv_pkg::CSR_MAX_LENGTH, cap);
      write_reg(utv_pkg::CSR_IDENT_ONLY, {{(utv_pkg::CSR_DATA_W-1){1'b0}}, ident});
      settings_made++;
      @(posedge clock);
      idle_on = idle;
   endtask

   initial begin : timeout
      #5000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : run_texts
      logic [31:0] dir_seq[12];
      int dir_n[12];
      logic [utv_pkg::MAX_LEN_W-1:0] ph_cap[PHASES];
      bit ph_ident[PHASES];
      int start;
      int guard;
      int long_len[3];

      dir_seq = '{32'h41, 32'h00, 32'h7f, 32'hc2a0, 32'hc29f, 32'he09fbf,
                  32'heda080, 32'hf4908080, 32'hf0908080, 32'h80, 32'he282, 32'hf5};
      dir_n = '{1, 1, 1, 2, 2, 3, 3, 4, 4, 1, 2, 1};
      ph_cap = '{13'd4096, 13'd0, 13'd1, 13'd5, 13'd4095,
                 13'd8191, 13'd16, 13'd3, 13'd4096, 13'd8191};
      ph_ident = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0};
      long_len = '{40, 41, 60};

      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.text_byte = '0;
      req_ch.final_byte = 1'b0;
      rsp_ch.ready = 1'b1;
      csr_ch.valid = 1'b0;
      csr_ch.index = utv_pkg::CSR_MAX_LENGTH;
      csr_ch.data = '0;
      len_cap = utv_pkg::MAX_LENGTH_RESET;
      ident_mode = 1'b0;
      cont_left = 2'd0;
      second_rule = utv_pkg::LEAD_ANY;
      at_second = 1'b0;
      text_len = '0;
      text_bad = 1'b0;
      idle_on = 1'b1;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // controls, C1, overlong, surrogate, above range, stray, cut short
      for (int t = 0; t < 12; t++) begin
         for (int i = dir_n[t] - 1; i >= 0; i--) add_byte(dir_seq[t][8*i +: 8]);
         commit_text(1'b0);
      end

      for (int p = 0; p < PHASES; p++) begin
         set_mode(ph_cap[p], ph_ident[p], p != PHASES - 1);
         start = bytes_queued;
         while (bytes_queued - start < 100) make_random_text(ph_ident[p]);
      end

      // length at the cap, just over it and well past it
      set_mode(13'd40, 1'b0, 1'b0);
      foreach (long_len[k]) begin
         repeat (long_len[k]) put_range(8'h20, 8'h7e);
         commit_text(1'b0);
      end

      do @(negedge clock); while (bytes_taken != bytes_queued);
      guard = 0;
      while (verdict_q.size() != 0 && guard < 2000) begin
         @(negedge clock);
         guard++;
      end
      repeat (8) @(negedge clock);
      if (verdict_q.size() != 0) report_bad("verdict never arrived", verdict_q[0], '0);

      $display("%0d texts in %0d bytes over %0d register settings",
               texts_made, bytes_taken, settings_made);
      $display("%0d texts expected to pass, %0d expected to be rejected", n_pass, n_reject);
      if (bad_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("%0d mismatches", bad_count);
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
